### rtl/core/bandit_index_calibration_sweep_top_macros.svh
// Assertion macros for the bandit index calibration block.
// Uses the clk and rst_n names of the module that includes this header.
`ifndef BANDIT_INDEX_CALIBRATION_SWEEP_TOP_MACROS_SVH
`define BANDIT_INDEX_CALIBRATION_SWEEP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BIC_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIC_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bic_pkg.sv
// Shared types and constants of the bandit index calibration block.
// No dependencies; used by the interfaces, the divider and the top level.
package bic_pkg;

  localparam int HZ_W       = 8;
  localparam int PROB_W     = 20;
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd2;

  localparam logic [HZ_W-1:0]   HORIZON_RST  = 8'd128;
  localparam logic [PROB_W-1:0] DISCOUNT_RST = 20'd996147;
  localparam logic [PROB_W-1:0] STEP_RST     = 20'd105;

  // Divider: dividend holds up to s*(2^20+b1)+f*b2, divisor up to 2^20.
  localparam int DIV_DW = 44;
  localparam int DIV_VW = 21;
  localparam int DIV_CW = 6;
  localparam logic [DIV_VW-1:0] FRAC_ONE = 21'h100000;

  localparam int MUL_AW = 33;
  localparam int MUL_BW = 20;
  localparam int PROD_W = MUL_AW + MUL_BW;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SWP, ST_SAFE_W, ST_Q0, ST_Q0_W, ST_TERM,
    ST_RA, ST_RB, ST_RC, ST_RD, ST_RE, ST_RF, ST_DIV, ST_UPD,
    ST_RDCHK, ST_RDW, ST_DONE
  } bic_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bic_div_sts_t;

  function automatic logic [VAL_W-1:0] sat32(input logic [DIV_DW-1:0] q);
    logic [VAL_W-1:0] r;
    r = (|q[DIV_DW-1:VAL_W]) ? {VAL_W{1'b1}} : q[VAL_W-1:0];
    return r;
  endfunction

endpackage

### rtl/core/bic_if.sv
// Valid/ready channel interfaces for sweep/read items and their results.
// Depends on bic_pkg for the field widths.
interface bic_in_if;
  import bic_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [PROB_W-1:0] calib_prob;
  logic [CNT_W-1:0]  successes;
  logic [CNT_W-1:0]  failures;
  modport source (output valid, func, calib_prob, successes, failures, input ready);
  modport sink   (input valid, func, calib_prob, successes, failures, output ready);
endinterface

interface bic_out_if;
  import bic_pkg::*;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] index_value;
  modport source (output valid, index_value, input ready);
  modport sink   (input valid, index_value, output ready);
endinterface

### rtl/core/bic_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bic_pkg for widths and the status struct.
module bic_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bic_pkg::DIV_DW-1:0]    dividend,
  input  logic [bic_pkg::DIV_VW-1:0]    divisor,
  output bic_pkg::bic_div_sts_t         sts,
  output logic [bic_pkg::DIV_DW-1:0]    quotient,
  output logic [bic_pkg::DIV_VW-1:0]    remainder
);
  import bic_pkg::*;

  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] rem_r, dvs_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r, ge;
  logic [DIV_VW:0]   trial, diff;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_DW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/core/bandit_index_calibration_sweep_top.sv
// Bernoulli bandit index calibration. A sweep transaction (func 0) runs one
// backward induction over all states below the horizon; a read transaction
// (func 1) returns a recorded index. After reset a clearing pass zeroes the
// index memory before the first transaction. Each state of a sweep does
// memory reads and four multiplies on one shared multiplier, a pass of the
// shared bit-serial divider, which dominates, and one update step.
`include "bandit_index_calibration_sweep_top_macros.svh"

module bandit_index_calibration_sweep_top #(
  parameter int MAX_N = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bic_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  bic_in_if.sink                          in_if,
  bic_out_if.source                       out_if
);
  import bic_pkg::*;

  localparam int NW    = $clog2(MAX_N + 1);
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (NW > HZ_W) ? NW : HZ_W;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] s, input logic [AW-1:0] f);
    return AW'(s * MAX_N + f);
  endfunction

  bic_state_t state_r, state_nxt;

  logic [HZ_W-1:0]   horizon_r;
  logic [PROB_W-1:0] discount_r, step_r, p_r, mark_r, res_r;
  logic              func_r;
  logic [CNT_W-1:0]  rs_r, rf_r;
  logic [NW-1:0]     n_r, nn_r, s_r, r0_r, tr_r, f_cur;
  logic [NW:0]       tr_sum;
  logic [DIV_VW-1:0] q0_r, tq_r;
  logic [VAL_W-1:0]  safe_r, b1_r, b2_r, risky, best;
  logic [DIV_DW-1:0] acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  logic [PROB_W-1:0] out_data_r;
  logic [CW-1:0]     hz_ext, n_eff;
  logic              rd_ok, in_acc, out_load;

  // Memories and their controls.
  logic [VAL_W-1:0]  vmem [DEPTH];
  logic [PROB_W-1:0] rmem [DEPTH];
  logic [VAL_W-1:0]  vmem_q, v_wdata;
  logic [PROB_W-1:0] rec_q, rec_wdata;
  logic              v_re, v_we, rec_re, rec_we;
  logic [AW-1:0]     v_raddr, v_waddr, rec_raddr, rec_waddr;
  logic [AW-1:0]     addr_a, addr_b, addr_c, addr_t, addr_rd;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;

  logic              div_start;
  logic [DIV_DW-1:0] div_dividend, div_q;
  logic [DIV_VW-1:0] div_divisor, div_rem;
  bic_div_sts_t      div_sts;

  bic_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign in_if.ready      = (state_r == ST_IDLE);
  assign in_acc           = in_if.valid && in_if.ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.index_value = out_data_r;
  assign out_load         = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    hz_ext = CW'(horizon_r);
    n_eff  = (hz_ext > CW'(MAX_N)) ? CW'(MAX_N) : hz_ext;
    f_cur  = nn_r - s_r;
    addr_a = slot(AW'(s_r + NW'(1)), AW'(f_cur));
    addr_b = slot(AW'(s_r), AW'(f_cur + NW'(1)));
    addr_c = slot(AW'(s_r), AW'(f_cur));
    addr_t = slot(AW'(s_r), AW'(n_r - s_r));
    addr_rd = slot(AW'(rs_r), AW'(rf_r));
    rd_ok  = (rs_r != '0) && (rf_r != '0) && (32'(rs_r) < MAX_N) && (32'(rf_r) < MAX_N);
    risky  = sat32(div_q);
    best   = (safe_r > risky) ? safe_r : risky;
    tr_sum = {1'b0, tr_r} + {1'b0, r0_r};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = in_if.func ? ST_RDCHK : ST_SWP;
      ST_SWP:    state_nxt = (n_r < NW'(3)) ? ST_DONE : ST_SAFE_W;
      ST_SAFE_W: if (div_sts.done) state_nxt = ST_Q0;
      ST_Q0:     state_nxt = ST_Q0_W;
      ST_Q0_W:   if (div_sts.done) state_nxt = ST_TERM;
      ST_TERM:   if (s_r == n_r - NW'(1)) state_nxt = ST_RA;
      ST_RA:     state_nxt = ST_RB;
      ST_RB:     state_nxt = ST_RC;
      ST_RC:     state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_RE;
      ST_RE:     state_nxt = ST_RF;
      ST_RF:     state_nxt = ST_DIV;
      ST_DIV:    if (div_sts.done) state_nxt = ST_UPD;
      ST_UPD: begin
        if (s_r + NW'(1) < nn_r || nn_r > NW'(2)) state_nxt = ST_RA;
        else state_nxt = ST_DONE;
      end
      ST_RDCHK:  state_nxt = rd_ok ? ST_RDW : ST_DONE;
      ST_RDW:    state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    v_re = 1'b0;  v_raddr = addr_a;
    v_we = 1'b0;  v_waddr = addr_c;  v_wdata = best;
    rec_re = 1'b0; rec_raddr = addr_c;
    rec_we = 1'b0; rec_waddr = addr_c; rec_wdata = mark_r;
    mul_a = MUL_AW'(vmem_q);
    mul_b = discount_r;
    div_start = 1'b0;
    div_dividend = {4'd0, p_r, 20'd0};
    div_divisor  = FRAC_ONE - DIV_VW'(discount_r);
    unique case (state_r)
      ST_CLEAR: begin
        rec_we = 1'b1; rec_waddr = clr_cnt_r; rec_wdata = '0;
      end
      ST_SWP: div_start = (n_r >= NW'(3));
      ST_Q0: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(FRAC_ONE);
        div_divisor  = DIV_VW'(n_r);
      end
      ST_TERM: begin
        v_we = 1'b1; v_waddr = addr_t; v_wdata = VAL_W'(tq_r);
      end
      ST_RA: v_re = 1'b1;
      ST_RB: begin
        v_re = 1'b1; v_raddr = addr_b; rec_re = 1'b1;
      end
      ST_RD: begin
        mul_a = MUL_AW'(FRAC_ONE) + MUL_AW'(b1_r);
        mul_b = MUL_BW'(s_r);
      end
      ST_RE: begin
        mul_a = MUL_AW'(b2_r);
        mul_b = MUL_BW'(f_cur);
      end
      ST_RF: begin
        div_start    = 1'b1;
        div_dividend = acc_r + prod_r[DIV_DW-1:0];
        div_divisor  = DIV_VW'(nn_r);
      end
      ST_UPD: begin
        v_we   = 1'b1;
        rec_we = (rec_q == '0) && (safe_r > risky);
      end
      ST_RDCHK: begin
        rec_re = rd_ok; rec_raddr = addr_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    if (v_re) vmem_q <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rmem[rec_waddr] <= rec_wdata;
    if (rec_re) rec_q <= rmem[rec_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      horizon_r   <= HORIZON_RST;
      discount_r  <= DISCOUNT_RST;
      step_r      <= STEP_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_HORIZON:  horizon_r  <= cfg_wdata[HZ_W-1:0];
          CFG_DISCOUNT: discount_r <= cfg_wdata;
          CFG_STEP:     step_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload and loop counters.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (out_load) out_data_r <= res_r;
    unique case (state_r)
      ST_IDLE: begin
        func_r <= in_if.func;
        p_r    <= in_if.calib_prob;
        rs_r   <= in_if.successes;
        rf_r   <= in_if.failures;
        n_r    <= NW'(n_eff);
        res_r  <= '0;
        mark_r <= (in_if.calib_prob >= (step_r >> 1)) ?
                  in_if.calib_prob - (step_r >> 1) : '0;
      end
      ST_SAFE_W: if (div_sts.done) safe_r <= sat32(div_q);
      ST_Q0_W: begin
        if (div_sts.done) begin
          q0_r <= div_q[DIV_VW-1:0];
          tq_r <= div_q[DIV_VW-1:0];
          r0_r <= NW'(div_rem);
          tr_r <= NW'(div_rem);
          s_r  <= NW'(1);
        end
      end
      ST_TERM: begin
        // Running quotient and remainder of s*2^20/n.
        if (tr_sum >= {1'b0, n_r}) begin
          tq_r <= tq_r + q0_r + DIV_VW'(1);
          tr_r <= NW'(tr_sum - {1'b0, n_r});
        end else begin
          tq_r <= tq_r + q0_r;
          tr_r <= NW'(tr_sum);
        end
        if (s_r == n_r - NW'(1)) begin
          nn_r <= n_r - NW'(1);
          s_r  <= NW'(1);
        end else begin
          s_r <= s_r + NW'(1);
        end
      end
      ST_RC: b1_r <= prod_r[51:20];
      ST_RD: b2_r <= prod_r[51:20];
      ST_RE: acc_r <= prod_r[DIV_DW-1:0];
      ST_UPD: begin
        if (s_r + NW'(1) < nn_r) begin
          s_r <= s_r + NW'(1);
        end else begin
          nn_r <= nn_r - NW'(1);
          s_r  <= NW'(1);
        end
      end
      ST_RDW: res_r <= rec_q;
      default: ;
    endcase
  end

  `BIC_CHECK_IMP(a_no_accept_in_clear, state_r == ST_CLEAR, !in_if.ready, "ready during clear")
  `BIC_CHECK_IMP(a_div_start_idle, div_start, !div_sts.busy, "divider restarted while busy")
  `BIC_CHECK_IMP(a_rec_once, rec_we && state_r == ST_UPD, rec_q == '0, "index overwritten")
  `BIC_CHECK_NXT(a_busy_after_accept, in_acc, !in_if.ready, "ready held after accept")
  `BIC_CHECK_IMP(a_sweep_result_zero, out_load && !func_r, res_r == '0, "nonzero sweep result")

endmodule
